>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on i_clk and
// is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/wfpid_pkg.sv
package wfpid_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int SUM_BITS_DEF    = 24;
    localparam int GAIN_BITS       = 8;
    localparam int SPEED_BITS      = 11;
    localparam int SIDE_BITS       = 2;
    localparam int CFG_IDX_BITS    = 3;

    localparam int MOTOR_MID  = 512;
    localparam int TERM_LIMIT = 512;

    localparam int LEFT_THR_RST  = 348;
    localparam int RIGHT_THR_RST = 307;
    localparam int PROP_GAIN_RST = 5;
    localparam int INT_GAIN_RST  = 0;
    localparam int DER_GAIN_RST  = 0;

    typedef enum logic [SIDE_BITS-1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } t_side;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LEFT_THR   = 3'd0,
        CFG_RIGHT_THR  = 3'd1,
        CFG_LEFT_KP    = 3'd2,
        CFG_RIGHT_KP   = 3'd3,
        CFG_LEFT_KI    = 3'd4,
        CFG_RIGHT_KI   = 3'd5,
        CFG_LEFT_KD    = 3'd6,
        CFG_RIGHT_KD   = 3'd7
    } t_cfg_idx;

endpackage

>>> rtl/wall_follow_pid_controller.sv
// Path: a request is accepted into the input register, and its result moves
// from there into the output register.
// Throughput: one request per cycle while the output is not stalled. The whole update,
// from peaks to speeds, is combinational between the input register and the output register.
// Reset: i_rst_n is synchronous and active low; it restores the register
// defaults, clears peaks, integral and last error, and selects no wall.
`include "assert_macros.svh"

module wall_follow_pid_controller
    import wfpid_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = SUM_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Sample request channel.
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [SAMPLE_BITS-1:0]  i_left_sample,
    input  logic [SAMPLE_BITS-1:0]  i_right_sample,
    // Result channel.
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [SPEED_BITS-1:0]   o_left_speed,
    output logic [SPEED_BITS-1:0]   o_right_speed,
    output logic [SIDE_BITS-1:0]    o_followed_side,
    output logic                    o_side_changed,
    output logic                    o_left_wall_seen,
    output logic                    o_right_wall_seen,
    // Register write channel.
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [SAMPLE_BITS-1:0]  i_cfg_data
);

    // Derived widths. The error is the sample minus a threshold, the
    // derivative input is a difference of two errors, and the integral
    // update needs one spare bit above the wider of sum and error.
    localparam int EW   = SAMPLE_BITS + 1;
    localparam int DFW  = SAMPLE_BITS + 2;
    localparam int SUMX = ((SUM_BITS > EW) ? SUM_BITS : EW) + 1;
    localparam int W5   = SAMPLE_BITS + 3;
    localparam int PW   = GAIN_BITS + 1 + EW;
    localparam int IW   = GAIN_BITS + 1 + SUM_BITS;
    localparam int DW   = GAIN_BITS + 1 + DFW;
    localparam int MXW  = (IW > DW) ? IW : DW;
    localparam int TW   = MXW + 2;

    localparam logic signed [TW-1:0]         LIM_HI = TW'(TERM_LIMIT);
    localparam logic signed [TW-1:0]         LIM_LO = -LIM_HI;
    localparam logic        [SPEED_BITS-1:0] MID    = SPEED_BITS'(MOTOR_MID);
    localparam logic        [SPEED_BITS:0]   SPEED_TOTAL = (SPEED_BITS+1)'(2 * MOTOR_MID);

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the block is
    // idle, which the block itself does not enforce; the port is always ready and the values are used directly.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] r_left_thr, r_right_thr;
    logic [GAIN_BITS-1:0]   r_left_kp, r_right_kp;
    logic [GAIN_BITS-1:0]   r_left_ki, r_right_ki;
    logic [GAIN_BITS-1:0]   r_left_kd, r_right_kd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_thr  <= SAMPLE_BITS'(LEFT_THR_RST);
            r_right_thr <= SAMPLE_BITS'(RIGHT_THR_RST);
            r_left_kp   <= GAIN_BITS'(PROP_GAIN_RST);
            r_right_kp  <= GAIN_BITS'(PROP_GAIN_RST);
            r_left_ki   <= GAIN_BITS'(INT_GAIN_RST);
            r_right_ki  <= GAIN_BITS'(INT_GAIN_RST);
            r_left_kd   <= GAIN_BITS'(DER_GAIN_RST);
            r_right_kd  <= GAIN_BITS'(DER_GAIN_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LEFT_THR:  r_left_thr  <= i_cfg_data;
                CFG_RIGHT_THR: r_right_thr <= i_cfg_data;
                CFG_LEFT_KP:   r_left_kp   <= i_cfg_data[GAIN_BITS-1:0];
                CFG_RIGHT_KP:  r_right_kp  <= i_cfg_data[GAIN_BITS-1:0];
                CFG_LEFT_KI:   r_left_ki   <= i_cfg_data[GAIN_BITS-1:0];
                CFG_RIGHT_KI:  r_right_ki  <= i_cfg_data[GAIN_BITS-1:0];
                CFG_LEFT_KD:   r_left_kd   <= i_cfg_data[GAIN_BITS-1:0];
                CFG_RIGHT_KD:  r_right_kd  <= i_cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The input register loads when it is empty or when its
    // request moves into the output register, and the output register
    // loads when it is empty or its result is being taken. A new request is
    // therefore taken in the same cycle that a finished result leaves.
    // ------------------------------------------------------------------
    logic r_v0;
    logic rdy0, rdy_out;
    logic adv;

    assign rdy_out    = !o_out_valid || !i_out_stall;
    assign rdy0       = !r_v0 || rdy_out;
    assign o_in_stall = !rdy0;
    // A request leaves the input register and updates the controller state.
    assign adv        = r_v0 && rdy_out;

    // Input register.
    logic [SAMPLE_BITS-1:0] r_ls0, r_rs0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (rdy0) begin
            r_v0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_ls0 <= i_left_sample;
            r_rs0 <= i_right_sample;
        end
    end

    // ------------------------------------------------------------------
    // Controller state: peaks, wall detection, wall choice and the integral.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0]     r_lpeak, r_rpeak;
    t_side                      r_side;
    logic signed [SUM_BITS-1:0] r_err_sum;
    logic signed [EW-1:0]       r_last_err;

    logic [SAMPLE_BITS-1:0] n_lpeak, n_rpeak;
    logic [W5-1:0]          l_x5, r_x5, l_p2, r_p2;
    logic                   lw, rw;

    assign n_lpeak = (r_ls0 > r_lpeak) ? r_ls0 : r_lpeak;
    assign n_rpeak = (r_rs0 > r_rpeak) ? r_rs0 : r_rpeak;

    // The wall test sample/peak >= 0.4 is done exactly as 5*sample >= 2*peak.
    assign l_x5 = W5'({r_ls0, 2'b00}) + W5'(r_ls0);
    assign r_x5 = W5'({r_rs0, 2'b00}) + W5'(r_rs0);
    assign l_p2 = {2'b00, n_lpeak, 1'b0};
    assign r_p2 = {2'b00, n_rpeak, 1'b0};
    assign lw   = (n_lpeak != '0) && (l_x5 >= l_p2);
    assign rw   = (n_rpeak != '0) && (r_x5 >= r_p2);

    // Wall choice, next state. With no wall the right one wins; a followed
    // wall is kept while it is seen and, when lost, handed to the other side if that one is seen.
    t_side n_side;

    always_comb begin
        n_side = r_side;
        unique case (r_side)
            SIDE_NONE: begin
                if (rw) begin
                    n_side = SIDE_RIGHT;
                end else if (lw) begin
                    n_side = SIDE_LEFT;
                end
            end
            SIDE_RIGHT: begin
                if (!rw) begin
                    if (lw) begin
                        n_side = SIDE_LEFT;
                    end else begin
                        n_side = SIDE_NONE;
                    end
                end
            end
            SIDE_LEFT: begin
                if (!lw) begin
                    if (rw) begin
                        n_side = SIDE_RIGHT;
                    end else begin
                        n_side = SIDE_NONE;
                    end
                end
            end
            default: begin
                n_side = SIDE_NONE;
            end
        endcase
    end

    // Wall choice, outputs: the change flag and the side-specific operands.
    logic                   changed, following, left_sel;
    logic [SAMPLE_BITS-1:0] sel_sample, sel_thr;
    logic [GAIN_BITS-1:0]   sel_kp, sel_ki, sel_kd;

    always_comb begin
        changed    = (n_side != r_side);
        following  = (n_side != SIDE_NONE);
        left_sel   = (n_side == SIDE_LEFT);
        sel_sample = left_sel ? r_ls0      : r_rs0;
        sel_thr    = left_sel ? r_left_thr : r_right_thr;
        sel_kp     = left_sel ? r_left_kp  : r_right_kp;
        sel_ki     = left_sel ? r_left_ki  : r_right_ki;
        sel_kd     = left_sel ? r_left_kd  : r_right_kd;
    end

    // Error, derivative difference and the saturating integral. A change of
    // wall starts both the integral and the last error from zero.
    logic signed [EW-1:0]       err, base_last;
    logic signed [DFW-1:0]      diff;
    logic signed [SUM_BITS-1:0] base_sum, n_sum;
    logic signed [SUMX-1:0]     sum_ext;
    logic                       sum_ovf;

    always_comb begin
        err       = $signed({1'b0, sel_sample}) - $signed({1'b0, sel_thr});
        base_last = changed ? '0 : r_last_err;
        base_sum  = changed ? '0 : r_err_sum;
        diff      = $signed({err[EW-1], err}) - $signed({base_last[EW-1], base_last});
        sum_ext   = $signed({{(SUMX-SUM_BITS){base_sum[SUM_BITS-1]}}, base_sum})
                  + $signed({{(SUMX-EW){err[EW-1]}}, err});
        // Overflow when the bits above the sum's sign do not all match it.
        sum_ovf   = (sum_ext[SUMX-1:SUM_BITS-1] != {(SUMX-SUM_BITS+1){1'b0}})
                 && (sum_ext[SUMX-1:SUM_BITS-1] != {(SUMX-SUM_BITS+1){1'b1}});
        if (sum_ovf) begin
            n_sum = sum_ext[SUMX-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                    : {1'b0, {(SUM_BITS-1){1'b1}}};
        end else begin
            n_sum = sum_ext[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpeak    <= '0;
            r_rpeak    <= '0;
            r_side     <= SIDE_NONE;
            r_err_sum  <= '0;
            r_last_err <= '0;
        end else if (adv) begin
            r_lpeak <= n_lpeak;
            r_rpeak <= n_rpeak;
            r_side  <= n_side;
            // With no wall the integral and last error hold, unless the wall
            // was just lost, in which case they are cleared.
            if (following || changed) begin
                r_err_sum  <= following ? n_sum : '0;
                r_last_err <= following ? err   : '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Gain products, their sum limited to +-512, and the speeds. The
    // integral product uses the integral after this request's update.
    // The followed side is pushed towards its wall by a positive term.
    // ------------------------------------------------------------------
    logic signed [PW-1:0]         pterm;
    logic signed [IW-1:0]         iterm;
    logic signed [DW-1:0]         dterm;
    logic signed [TW-1:0]         term, term_c;
    logic        [SPEED_BITS-1:0] term_s, n_lspeed, n_rspeed;

    assign pterm = $signed({1'b0, sel_kp}) * err;
    assign iterm = $signed({1'b0, sel_ki}) * n_sum;
    assign dterm = $signed({1'b0, sel_kd}) * diff;

    always_comb begin
        term = $signed({{(TW-PW){pterm[PW-1]}}, pterm})
             + $signed({{(TW-IW){iterm[IW-1]}}, iterm})
             + $signed({{(TW-DW){dterm[DW-1]}}, dterm});
        priority if (term > LIM_HI) begin
            term_c = LIM_HI;
        end else if (term < LIM_LO) begin
            term_c = LIM_LO;
        end else begin
            term_c = term;
        end
        term_s = term_c[SPEED_BITS-1:0];
        unique case (n_side)
            SIDE_LEFT: begin
                n_lspeed = MID + term_s;
                n_rspeed = MID - term_s;
            end
            SIDE_RIGHT: begin
                n_lspeed = MID - term_s;
                n_rspeed = MID + term_s;
            end
            default: begin
                n_lspeed = '0;
                n_rspeed = '0;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (rdy_out) begin
            o_out_valid <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            o_left_speed      <= n_lspeed;
            o_right_speed     <= n_rspeed;
            o_followed_side   <= n_side;
            o_side_changed    <= changed;
            o_left_wall_seen  <= lw;
            o_right_wall_seen <= rw;
        end
    end

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    logic                  out_no_wall, out_on_wall, out_lost_wall, speeds_zero;
    logic [SPEED_BITS:0]   speed_sum;

    assign out_no_wall   = o_out_valid && (o_followed_side == SIDE_NONE);
    assign out_on_wall   = o_out_valid && (o_followed_side != SIDE_NONE);
    assign out_lost_wall = o_out_valid
                        && (((o_followed_side == SIDE_LEFT) && !o_left_wall_seen)
                         || ((o_followed_side == SIDE_RIGHT) && !o_right_wall_seen));
    assign speeds_zero   = (o_left_speed == '0) && (o_right_speed == '0);
    assign speed_sum     = {1'b0, o_left_speed} + {1'b0, o_right_speed};

    `ASSERT_SAME(a_no_wall_stops, out_no_wall, speeds_zero, "motors not stopped with no wall")
    `ASSERT_SAME(a_speed_balance, out_on_wall, speed_sum == SPEED_TOTAL, "speeds off balance")
    `ASSERT_SAME(a_followed_seen, out_lost_wall, 1'b0, "followed wall is not seen")
    `ASSERT_NEXT(a_state_hold, !adv, $stable({r_side, r_err_sum, r_last_err}), "idle state moved")

endmodule
